// ----- rtl/sdl_pkg.sv -----
// Shared types and constants for the service displacement lifecycle block.
// No dependencies; every other file imports this package.
package sdl_pkg;

    localparam int SERVICES_DEF = 8;

    localparam int CMD_W    = 3;
    localparam int SVC_W    = 8;
    localparam int STATUS_W = 3;
    localparam int STATE_W  = 3;
    localparam int MASK_W   = 8;
    localparam int FSVC_W   = 4;

    localparam logic [MASK_W-1:0] CANCEL_MASK_RST = 8'hFF;

    // Services 0 to 7 have a cancellable bit and a displaced mask bit
    localparam logic [SVC_W-1:0] MASKED_SVCS = 8'd8;
    localparam logic signed [FSVC_W-1:0] FSVC_NONE = -4'sd1;
    localparam logic signed [FSVC_W-1:0] FSVC_SAT  = 4'sd7;

    localparam logic [CMD_W-1:0] CMD_REQUEST      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_QUIESCE_DONE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESTORE_DONE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR_FAULT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY        = 3'd5;

    typedef enum logic [STATE_W-1:0] {
        ST_FREE      = 3'd0,
        ST_QUIESCING = 3'd1,
        ST_DISPLACED = 3'd2,
        ST_RESTORING = 3'd3,
        ST_FAULT     = 3'd4
    } t_state;

    typedef enum logic [STATUS_W-1:0] {
        RS_OK            = 3'd0,
        RS_INVALID       = 3'd1,
        RS_ALREADY       = 3'd2,
        RS_WRONG         = 3'd3,
        RS_NOT_CANCEL    = 3'd4,
        RS_NOT_DISPLACED = 3'd5
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SVC_W-1:0] service;
        logic             restore_ok;
    } t_item;

    typedef struct packed {
        t_status                   status;
        t_state                    service_state;
        logic [MASK_W-1:0]         displaced_mask;
        logic                      any_fault;
        logic signed [FSVC_W-1:0]  fault_service;
    } t_result;

endpackage

// ----- rtl/sdl_in_if.sv -----
// Command channel: valid/ready handshake carrying one command word.
// Depends on sdl_pkg for field widths.
interface sdl_in_if import sdl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [SVC_W-1:0] service;
    logic             restore_ok;

    modport source (output valid, output cmd, output service, output restore_ok, input ready);
    modport sink   (input valid, input cmd, input service, input restore_ok, output ready);
endinterface

// ----- rtl/sdl_out_if.sv -----
// Result channel: valid/ready handshake carrying one result word.
// Depends on sdl_pkg for field widths.
interface sdl_out_if import sdl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [STATE_W-1:0]        service_state;
    logic [MASK_W-1:0]         displaced_mask;
    logic                      any_fault;
    logic signed [FSVC_W-1:0]  fault_service;

    modport source (output valid, output status, output service_state,
                    output displaced_mask, output any_fault, output fault_service,
                    input ready);
    modport sink   (input valid, input status, input service_state,
                    input displaced_mask, input any_fault, input fault_service,
                    output ready);
endinterface

// ----- rtl/sdl_core.sv -----
// Per-service state table with the command read-modify-write and the
// displaced mask / fault priority summary. Depends on sdl_pkg.
module sdl_core import sdl_pkg::*; #(
    parameter int SERVICES = SERVICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_item             i_item,
    input  logic [MASK_W-1:0] i_cancel_mask,
    output t_result           o_result
);

    localparam int IDX_W = (SERVICES > 1) ? $clog2(SERVICES) : 1;
    localparam int PAD_W = (SERVICES > MASK_W) ? SERVICES : MASK_W;
    localparam logic [SVC_W-1:0] SVC_LIMIT = SVC_W'(SERVICES);

    t_state r_states [SERVICES];
    t_state n_states [SERVICES];

    logic             w_valid;
    logic [IDX_W-1:0] w_idx;
    logic             w_cancel_ok;
    t_state           w_cur;
    t_status          w_status;
    logic [PAD_W-1:0] w_disp;

    assign w_valid     = i_item.service < SVC_LIMIT;
    assign w_idx       = i_item.service[IDX_W-1:0];
    assign w_cancel_ok = (i_item.service < MASKED_SVCS) && i_cancel_mask[i_item.service[2:0]];

    always_comb begin
        n_states = r_states;
        w_cur    = r_states[w_idx];
        w_status = RS_OK;
        if (!w_valid) begin
            w_status = RS_INVALID;
        end else begin
            case (i_item.cmd)
                CMD_REQUEST: begin
                    if (w_cur == ST_DISPLACED || w_cur == ST_QUIESCING) begin
                        w_status = RS_ALREADY;
                    end else if (w_cur != ST_FREE) begin
                        w_status = RS_WRONG;
                    end else if (!w_cancel_ok) begin
                        w_status = RS_NOT_CANCEL;
                    end else begin
                        n_states[w_idx] = ST_QUIESCING;
                    end
                end
                CMD_QUIESCE_DONE: begin
                    if (w_cur != ST_QUIESCING) w_status = RS_WRONG;
                    else n_states[w_idx] = ST_DISPLACED;
                end
                CMD_RELEASE: begin
                    if (w_cur != ST_DISPLACED) w_status = RS_NOT_DISPLACED;
                    else n_states[w_idx] = ST_RESTORING;
                end
                CMD_RESTORE_DONE: begin
                    if (w_cur != ST_RESTORING) w_status = RS_WRONG;
                    else n_states[w_idx] = i_item.restore_ok ? ST_FREE : ST_FAULT;
                end
                CMD_CLEAR_FAULT: begin
                    if (w_cur != ST_FAULT) w_status = RS_WRONG;
                    else n_states[w_idx] = ST_FREE;
                end
                // query and the unused codes leave the table alone
                default: w_status = RS_OK;
            endcase
        end
    end

    // Summaries are taken from the table as it stands after this command
    always_comb begin
        w_disp = '0;
        for (int i = 0; i < SERVICES; i++) begin
            w_disp[i] = (n_states[i] == ST_DISPLACED);
        end
    end

    always_comb begin
        o_result.status         = w_status;
        o_result.service_state  = w_valid ? n_states[w_idx] : ST_FREE;
        o_result.displaced_mask = w_disp[MASK_W-1:0];
        o_result.any_fault      = 1'b0;
        o_result.fault_service  = FSVC_NONE;
        // scan downward so the lowest faulted index wins
        for (int i = SERVICES - 1; i >= 0; i--) begin
            if (n_states[i] == ST_FAULT) begin
                o_result.any_fault     = 1'b1;
                o_result.fault_service = (i > 7) ? FSVC_SAT : FSVC_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SERVICES; i++) r_states[i] <= ST_FREE;
        end else if (i_step) begin
            r_states <= n_states;
        end
    end

endmodule

// ----- rtl/service_displacement_lifecycle.sv -----
// Top level of the service displacement lifecycle block: input register,
// result register and the cancellable mask. Depends on sdl_pkg, sdl_in_if,
// sdl_out_if and sdl_core.
//
// Usage:
//   i_item carries command words (cmd, service, restore_ok); o_result
//   returns one result word per command (status, service_state,
//   displaced_mask, any_fault, fault_service). Both use valid/ready.
//   i_cfg_we / i_cfg_data write the 8-bit cancellable mask, reset 0xFF.
// Timing:
//   A command is captured in the input register when it is accepted, then
//   applied to the state table and captured in the result register once the
//   result register is free or being read; the result is offered from the
//   result register. One command per cycle is sustained while o_result is
//   not stalled; the table read-modify-write sits between the two registers.
// Reset (synchronous, active low): all services free, mask 0xFF, both
//   registers empty.
// Stall: while o_result is held, the result register keeps its word and the
//   input register still takes one more command; after that i_item.ready
//   drops until the result is taken.
module service_displacement_lifecycle import sdl_pkg::*; #(
    parameter int SERVICES = SERVICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sdl_in_if.sink            i_item,
    sdl_out_if.source         o_result,
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_data
);

    logic              r_in_valid;
    t_item             r_in;
    logic              r_out_valid;
    t_result           r_res;
    logic [MASK_W-1:0] r_cancel_mask;

    logic    w_adv;
    logic    w_in_ready;
    t_result w_core_res;

    assign w_adv      = r_in_valid && (!r_out_valid || o_result.ready);
    assign w_in_ready = !r_in_valid || w_adv;

    sdl_core #(
        .SERVICES(SERVICES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_adv),
        .i_item       (r_in),
        .i_cancel_mask(r_cancel_mask),
        .o_result     (w_core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cancel_mask <= CANCEL_MASK_RST;
        end else begin
            if (w_in_ready) r_in_valid <= i_item.valid;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) r_cancel_mask <= i_cfg_data;
        end
    end

    // payload registers: hold unless advancing
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_item.valid) begin
            r_in.cmd        <= i_item.cmd;
            r_in.service    <= i_item.service;
            r_in.restore_ok <= i_item.restore_ok;
        end
        if (w_adv) r_res <= w_core_res;
    end

    assign i_item.ready            = w_in_ready;
    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_res.status;
    assign o_result.service_state  = r_res.service_state;
    assign o_result.displaced_mask = r_res.displaced_mask;
    assign o_result.any_fault      = r_res.any_fault;
    assign o_result.fault_service  = r_res.fault_service;

endmodule
